@@ hdl/ffpa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffpa_pkg
// shared types, codes and defaults of the first-fit partition allocator
// ----------------------------------------------------------------------------
package ffpa_pkg;

    localparam int unsigned MAX_PARTITIONS_DEF = 16;
    localparam logic [15:0] MEM_LENGTH_RST     = 16'd4096;

    localparam logic       ACT_ALLOC   = 1'b0;
    localparam logic       ACT_RELEASE = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_NOOWNER = 2'd3;

    typedef struct packed {
        logic [15:0] start;
        logic [15:0] size;
        logic [7:0]  owner;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_A_RD,
        S_A_EV,
        S_TAIL,
        S_C_RD,
        S_C_EV,
        S_APPEND,
        S_INS,
        S_I_EV,
        S_R_RD,
        S_R_EV,
        S_D_CHK,
        S_D_EV,
        S_DONE
    } t_state;

endpackage

@@ hdl/ffpa_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffpa_mem
// partition table: one write port, one read port with registered data
// ----------------------------------------------------------------------------
module ffpa_mem #(
    parameter int unsigned DEPTH = ffpa_pkg::MAX_PARTITIONS_DEF,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  ffpa_pkg::t_entry i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output ffpa_pkg::t_entry o_rdata
);

    ffpa_pkg::t_entry r_mem [DEPTH];
    ffpa_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/ffpa_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffpa_ctrl
// sequencer: scans, shifts and compacts the partition table one entry a step
// ----------------------------------------------------------------------------
module ffpa_ctrl #(
    parameter int unsigned MAX_PARTITIONS = ffpa_pkg::MAX_PARTITIONS_DEF,
    parameter int unsigned AW = $clog2(MAX_PARTITIONS),
    parameter int unsigned CW = $clog2(MAX_PARTITIONS + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_clear,
    input  logic [15:0]      i_mem_length,
    input  logic             i_start,
    input  logic             i_action,
    input  logic [7:0]       i_process_id,
    input  logic [15:0]      i_block_size,
    output logic             o_busy,
    output logic             o_result_valid,
    output logic [1:0]       o_status,
    output logic [15:0]      o_start_address,
    output logic [15:0]      o_free_units,
    output logic             o_mem_we,
    output logic [AW-1:0]    o_mem_waddr,
    output ffpa_pkg::t_entry o_mem_wdata,
    output logic [AW-1:0]    o_mem_raddr,
    input  ffpa_pkg::t_entry i_mem_rdata
);

    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_PARTITIONS);

    ffpa_pkg::t_state r_state, n_state;
    logic [AW-1:0] r_idx, n_idx;
    logic [AW-1:0] r_pos, n_pos;
    logic [CW-1:0] r_count, n_count;
    logic [15:0]   r_free, n_free;
    logic [16:0]   r_prev_end, n_prev_end;
    logic          r_action, n_action;
    logic [7:0]    r_owner, n_owner;
    logic [15:0]   r_size, n_size;
    logic [1:0]    r_status, n_status;
    logic [15:0]   r_addr, n_addr;

    logic [16:0]   ent_start;
    logic [16:0]   ent_end;
    logic [16:0]   mem_len_x;
    logic [16:0]   size_x;
    logic          gap_fits;
    logic          tail_short;
    logic          idx_last;
    logic          idx_next_end;

    assign ent_start    = {1'b0, i_mem_rdata.start};
    assign ent_end      = ent_start + {1'b0, i_mem_rdata.size};
    assign mem_len_x    = {1'b0, i_mem_length};
    assign size_x       = {1'b0, r_size};
    assign gap_fits     = (ent_start >= r_prev_end) && ((ent_start - r_prev_end) >= size_x);
    assign tail_short   = (r_prev_end > mem_len_x) || ((mem_len_x - r_prev_end) < size_x);
    assign idx_last     = (CW'(r_idx) + CW'(1)) == r_count;
    assign idx_next_end = (CW'(r_idx) + CW'(1)) >= r_count;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ffpa_pkg::S_IDLE: begin
                if (i_start) begin
                    n_state = ffpa_pkg::S_CHECK;
                end
            end
            ffpa_pkg::S_CHECK: begin
                if (r_action == ffpa_pkg::ACT_ALLOC) begin
                    if ({1'b0, r_size} > {1'b0, r_free} || r_count == CNT_MAX) begin
                        n_state = ffpa_pkg::S_DONE;
                    end else if (r_count == '0) begin
                        n_state = ffpa_pkg::S_TAIL;
                    end else begin
                        n_state = ffpa_pkg::S_A_RD;
                    end
                end else if (r_count == '0) begin
                    n_state = ffpa_pkg::S_DONE;
                end else begin
                    n_state = ffpa_pkg::S_R_RD;
                end
            end
            ffpa_pkg::S_A_RD:   n_state = ffpa_pkg::S_A_EV;
            ffpa_pkg::S_A_EV: begin
                if (gap_fits) begin
                    n_state = ffpa_pkg::S_INS;
                end else if (idx_last) begin
                    n_state = ffpa_pkg::S_TAIL;
                end else begin
                    n_state = ffpa_pkg::S_A_RD;
                end
            end
            ffpa_pkg::S_TAIL: begin
                if (tail_short && r_count != '0) begin
                    n_state = ffpa_pkg::S_C_RD;
                end else begin
                    n_state = ffpa_pkg::S_APPEND;
                end
            end
            ffpa_pkg::S_C_RD:   n_state = ffpa_pkg::S_C_EV;
            ffpa_pkg::S_C_EV:   n_state = idx_last ? ffpa_pkg::S_APPEND : ffpa_pkg::S_C_RD;
            ffpa_pkg::S_APPEND: n_state = ffpa_pkg::S_INS;
            ffpa_pkg::S_INS:    n_state = (r_idx == r_pos) ? ffpa_pkg::S_DONE : ffpa_pkg::S_I_EV;
            ffpa_pkg::S_I_EV:   n_state = ffpa_pkg::S_INS;
            ffpa_pkg::S_R_RD:   n_state = ffpa_pkg::S_R_EV;
            ffpa_pkg::S_R_EV: begin
                if (i_mem_rdata.owner == r_owner) begin
                    n_state = ffpa_pkg::S_D_CHK;
                end else if (idx_last) begin
                    n_state = ffpa_pkg::S_DONE;
                end else begin
                    n_state = ffpa_pkg::S_R_RD;
                end
            end
            ffpa_pkg::S_D_CHK:  n_state = idx_next_end ? ffpa_pkg::S_DONE : ffpa_pkg::S_D_EV;
            ffpa_pkg::S_D_EV:   n_state = ffpa_pkg::S_D_CHK;
            ffpa_pkg::S_DONE:   n_state = ffpa_pkg::S_IDLE;
            default:            n_state = ffpa_pkg::S_IDLE;
        endcase
    end

    // datapath and table access
    always_comb begin
        n_idx       = r_idx;
        n_pos       = r_pos;
        n_count     = r_count;
        n_free      = r_free;
        n_prev_end  = r_prev_end;
        n_action    = r_action;
        n_owner     = r_owner;
        n_size      = r_size;
        n_status    = r_status;
        n_addr      = r_addr;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_idx;
        o_mem_wdata = i_mem_rdata;
        o_mem_raddr = r_idx;
        case (r_state)
            ffpa_pkg::S_IDLE: begin
                if (i_start) begin
                    n_action = i_action;
                    n_owner  = i_process_id;
                    n_size   = i_block_size;
                end
            end
            ffpa_pkg::S_CHECK: begin
                n_idx      = '0;
                n_prev_end = '0;
                n_addr     = '0;
                n_status   = ffpa_pkg::ST_OK;
                if (r_action == ffpa_pkg::ACT_ALLOC) begin
                    if ({1'b0, r_size} > {1'b0, r_free}) begin
                        n_status = ffpa_pkg::ST_NOSPACE;
                    end else if (r_count == CNT_MAX) begin
                        n_status = ffpa_pkg::ST_FULL;
                    end
                end else if (r_count == '0) begin
                    n_status = ffpa_pkg::ST_NOOWNER;
                end
            end
            ffpa_pkg::S_A_EV: begin
                if (gap_fits) begin
                    n_pos  = r_idx;
                    n_addr = r_prev_end[15:0];
                    n_idx  = r_count[AW-1:0];
                end else begin
                    n_prev_end = ent_end;
                    n_idx      = r_idx + AW'(1);
                end
            end
            ffpa_pkg::S_TAIL: begin
                n_idx      = '0;
                if (tail_short) begin
                    n_prev_end = '0;
                end
            end
            ffpa_pkg::S_C_EV: begin
                // slide this entry down to the running end
                o_mem_we          = 1'b1;
                o_mem_wdata.start = r_prev_end[15:0];
                n_prev_end        = r_prev_end + {1'b0, i_mem_rdata.size};
                n_idx             = r_idx + AW'(1);
            end
            ffpa_pkg::S_APPEND: begin
                n_addr = r_prev_end[15:0];
                n_pos  = r_count[AW-1:0];
                n_idx  = r_count[AW-1:0];
            end
            ffpa_pkg::S_INS: begin
                if (r_idx == r_pos) begin
                    o_mem_we    = 1'b1;
                    o_mem_wdata = '{start: r_addr, size: r_size, owner: r_owner};
                    n_count     = r_count + CW'(1);
                    n_free      = r_free - r_size;
                end else begin
                    o_mem_raddr = r_idx - AW'(1);
                end
            end
            ffpa_pkg::S_I_EV: begin
                o_mem_we = 1'b1;
                n_idx    = r_idx - AW'(1);
            end
            ffpa_pkg::S_R_EV: begin
                if (i_mem_rdata.owner == r_owner) begin
                    n_free = r_free + i_mem_rdata.size;
                end else if (idx_last) begin
                    n_status = ffpa_pkg::ST_NOOWNER;
                end else begin
                    n_idx = r_idx + AW'(1);
                end
            end
            ffpa_pkg::S_D_CHK: begin
                o_mem_raddr = r_idx + AW'(1);
                if (idx_next_end) begin
                    n_count = r_count - CW'(1);
                end
            end
            ffpa_pkg::S_D_EV: begin
                o_mem_we = 1'b1;
                n_idx    = r_idx + AW'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffpa_pkg::S_IDLE;
            r_count <= '0;
            r_free  <= ffpa_pkg::MEM_LENGTH_RST;
        end else if (i_clear) begin
            r_state <= ffpa_pkg::S_IDLE;
            r_count <= '0;
            r_free  <= i_mem_length;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_free  <= n_free;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_pos      <= n_pos;
        r_prev_end <= n_prev_end;
        r_action   <= n_action;
        r_owner    <= n_owner;
        r_size     <= n_size;
        r_status   <= n_status;
        r_addr     <= n_addr;
    end

    assign o_busy          = (r_state != ffpa_pkg::S_IDLE);
    assign o_result_valid  = (r_state == ffpa_pkg::S_DONE);
    assign o_status        = r_status;
    assign o_start_address = (r_status == ffpa_pkg::ST_OK) ? r_addr : 16'd0;
    assign o_free_units    = r_free;

endmodule

@@ hdl/first_fit_partition_allocator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_partition_allocator_unit
// first-fit contiguous partition allocator with compaction
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; exactly one result
// follows on o_result_valid for a single cycle, and the receiver cannot stall
// it, so it must capture the result then. The partition table sits in a
// single-port-read memory with registered read data, and every step reads
// or writes one entry: an allocate scans entries for a hole, then either
// shifts entries up to open the slot or, when no hole fits and the tail is
// short, compacts the entries; a release scans for the owner and closes up
// the entries behind it. Writing mem_length (only while idle and no item is
// offered) empties the table and sets the free total.
// ----------------------------------------------------------------------------
module first_fit_partition_allocator_unit #(
    parameter int unsigned MAX_PARTITIONS = ffpa_pkg::MAX_PARTITIONS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_action,
    input  logic [7:0]  i_process_id,
    input  logic [15:0] i_block_size,
    output logic        o_result_valid,
    output logic [1:0]  o_status,
    output logic [15:0] o_start_address,
    output logic [15:0] o_free_units,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    localparam int unsigned AW = $clog2(MAX_PARTITIONS);

    logic [15:0]      r_mem_length;
    logic             cfg_we;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [AW-1:0]    mem_raddr;
    ffpa_pkg::t_entry mem_wdata;
    ffpa_pkg::t_entry mem_rdata;

    // an offered item goes first, so a write never drops it
    assign o_cfg_ready = !busy && !start;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_length <= ffpa_pkg::MEM_LENGTH_RST;
        end else if (cfg_we) begin
            r_mem_length <= i_cfg_data;
        end
    end

    ffpa_ctrl #(
        .MAX_PARTITIONS (MAX_PARTITIONS)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_clear         (cfg_we),
        .i_mem_length    (cfg_we ? i_cfg_data : r_mem_length),
        .i_start         (start),
        .i_action        (i_action),
        .i_process_id    (i_process_id),
        .i_block_size    (i_block_size),
        .o_busy          (busy),
        .o_result_valid  (o_result_valid),
        .o_status        (o_status),
        .o_start_address (o_start_address),
        .o_free_units    (o_free_units),
        .o_mem_we        (mem_we),
        .o_mem_waddr     (mem_waddr),
        .o_mem_wdata     (mem_wdata),
        .o_mem_raddr     (mem_raddr),
        .i_mem_rdata     (mem_rdata)
    );

    ffpa_mem #(
        .DEPTH (MAX_PARTITIONS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    a_result_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> busy)
        else $error("result strobe outside a request");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe longer than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_cfg_valid) |=> busy)
        else $error("accepted item did not start");

    a_fail_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_status != ffpa_pkg::ST_OK) |-> (o_start_address == 16'd0))
        else $error("failed request reports an address");

endmodule

@@ tb/ffpa_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffpa_checker
// watches the allocator ports, predicts every result and compares it
// ----------------------------------------------------------------------------
// Keeps its own copy of the partition table, the free total and the length
// register. Each accepted request is run through the table model at the
// accepting edge, and the outcome is queued. Each result strobe pops the
// oldest outcome and is compared field by field.
// ----------------------------------------------------------------------------
module ffpa_checker #(
    parameter int unsigned DEPTH = ffpa_pkg::MAX_PARTITIONS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        i_action,
    input  logic [7:0]  i_process_id,
    input  logic [15:0] i_block_size,
    input  logic        o_result_valid,
    input  logic [1:0]  o_status,
    input  logic [15:0] o_start_address,
    input  logic [15:0] o_free_units,
    input  logic        i_cfg_valid,
    input  logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] addr;
        logic [15:0] free;
    } t_outcome;

    t_outcome    outcome_q[$];
    int unsigned seg_start[DEPTH];
    int unsigned seg_size[DEPTH];
    logic [7:0]  seg_owner[DEPTH];
    int unsigned seg_count;
    int unsigned free_total;
    int unsigned mem_len;

    function automatic t_outcome run_request(logic act, logic [7:0] pid, logic [15:0] sz);
        t_outcome    r;
        int unsigned prev, pos, addr, tail, nxt;
        bit          found;
        r.status = ffpa_pkg::ST_OK;
        r.addr   = '0;
        if (act == ffpa_pkg::ACT_ALLOC) begin
            if (sz > free_total) begin
                r.status = ffpa_pkg::ST_NOSPACE;
            end else if (seg_count >= DEPTH) begin
                r.status = ffpa_pkg::ST_FULL;
            end else begin
                found = 0;
                prev  = 0;
                pos   = 0;
                addr  = 0;
                // first hole that fits, holes in address order
                for (int unsigned k = 0; k < seg_count; k++) begin
                    if (!found) begin
                        if (seg_start[k] >= prev && seg_start[k] - prev >= sz) begin
                            found = 1;
                            pos   = k;
                            addr  = prev;
                        end else begin
                            prev = seg_start[k] + seg_size[k];
                        end
                    end
                end
                if (!found) begin
                    tail = seg_count ? seg_start[seg_count-1] + seg_size[seg_count-1] : 0;
                    if (tail > mem_len || mem_len - tail < sz) begin
                        nxt = 0;
                        for (int unsigned k = 0; k < seg_count; k++) begin
                            seg_start[k] = nxt;
                            nxt += seg_size[k];
                        end
                        tail = nxt;
                    end
                    pos  = seg_count;
                    addr = tail;
                end
                for (int unsigned k = seg_count; k > pos; k--) begin
                    seg_start[k] = seg_start[k-1];
                    seg_size[k]  = seg_size[k-1];
                    seg_owner[k] = seg_owner[k-1];
                end
                seg_start[pos] = addr;
                seg_size[pos]  = 32'(sz);
                seg_owner[pos] = pid;
                seg_count++;
                free_total -= 32'(sz);
                r.addr = addr[15:0];
            end
        end else begin
            found = 0;
            pos   = 0;
            for (int unsigned k = 0; k < seg_count; k++) begin
                if (!found && seg_owner[k] == pid) begin
                    found = 1;
                    pos   = k;
                end
            end
            if (!found) begin
                r.status = ffpa_pkg::ST_NOOWNER;
            end else begin
                free_total = (free_total + seg_size[pos]) & 32'hFFFF;
                for (int unsigned k = pos; k + 1 < seg_count; k++) begin
                    seg_start[k] = seg_start[k+1];
                    seg_size[k]  = seg_size[k+1];
                    seg_owner[k] = seg_owner[k+1];
                end
                seg_count--;
            end
        end
        r.free = free_total[15:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            outcome_q.delete();
            seg_count  = 0;
            mem_len    = 32'(ffpa_pkg::MEM_LENGTH_RST);
            free_total = 32'(ffpa_pkg::MEM_LENGTH_RST);
            o_fail_count <= 0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                mem_len    = 32'(i_cfg_data);
                free_total = 32'(i_cfg_data);
                seg_count  = 0;
            end
            if (o_result_valid) begin
                if (outcome_q.size() == 0) begin
                    $display("%0t: unexpected result status=%0d addr=%0d free=%0d",
                             $time, o_status, o_start_address, o_free_units);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = outcome_q.pop_front();
                    if (o_status !== want.status || o_start_address !== want.addr ||
                        o_free_units !== want.free) begin
                        if (o_status !== want.status)
                            $display("%0t: status expected %0d got %0d",
                                     $time, want.status, o_status);
                        if (o_start_address !== want.addr)
                            $display("%0t: start_address expected %0d got %0d",
                                     $time, want.addr, o_start_address);
                        if (o_free_units !== want.free)
                            $display("%0t: free_units expected %0d got %0d",
                                     $time, want.free, o_free_units);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            // result of an item comes cycles after it is taken
            if (start && !busy)
                outcome_q.push_back(run_request(i_action, i_process_id, i_block_size));
        end
        o_pending <= outcome_q.size();
    end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the first-fit partition allocator
// ----------------------------------------------------------------------------
// Runs a directed part over the status codes, table full, zero size, duplicate
// owners and extreme lengths, then random allocate/release traffic with
// owners from a small pool under several lengths and idling profiles.
// ----------------------------------------------------------------------------
module tb_top;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_action;
    logic [7:0]  i_process_id;
    logic [15:0] i_block_size;
    logic        o_result_valid;
    logic [1:0]  o_status;
    logic [15:0] o_start_address;
    logic [15:0] o_free_units;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data;
    int          fail_count;
    int          pending;
    int          gap_pct;
    int unsigned cur_len;

    first_fit_partition_allocator_unit dut (.*);

    ffpa_checker chk (
        .i_clk, .i_rst_n, .start, .busy, .i_action, .i_process_id, .i_block_size,
        .o_result_valid, .o_status, .o_start_address, .o_free_units,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end

    task automatic send_item(logic act, logic [7:0] pid, logic [15:0] sz);
        if ($urandom_range(0, 99) < gap_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_action     <= act;
        i_process_id <= pid;
        i_block_size <= sz;
        do @(negedge i_clk); while (busy);
        @(posedge i_clk);
    endtask

    task automatic drain;
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic write_length(logic [15:0] len);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= len;
        do @(negedge i_clk); while (!o_cfg_ready);
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        cur_len = 32'(len);
    endtask

    task automatic random_item;
        int          r;
        logic [15:0] sz;
        r  = $urandom_range(0, 99);
        sz = 16'($urandom_range(1, cur_len / 6 + 1));
        if (r < 55)
            send_item(ffpa_pkg::ACT_ALLOC, 8'($urandom_range(0, 19)), sz);
        else if (r < 85)
            send_item(ffpa_pkg::ACT_RELEASE, 8'($urandom_range(0, 19)),
                      16'($urandom_range(0, 65535)));
        else
            send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                      16'($urandom_range(0, 65535)));
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_action     <= ffpa_pkg::ACT_ALLOC;
        i_process_id <= '0;
        i_block_size <= '0;
        i_cfg_valid  <= 1'b0;
        i_cfg_data   <= '0;
        gap_pct      = 0;
        cur_len      = 32'(ffpa_pkg::MEM_LENGTH_RST);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero size, too large, fill to full, unknown owner, holes
        send_item(ffpa_pkg::ACT_ALLOC, 8'd0, 16'd0);
        send_item(ffpa_pkg::ACT_ALLOC, 8'd255, 16'hFFFF);
        for (int i = 1; i <= 15; i++)
            send_item(ffpa_pkg::ACT_ALLOC, 8'(i), 16'd100);
        send_item(ffpa_pkg::ACT_ALLOC, 8'd200, 16'd1);
        send_item(ffpa_pkg::ACT_RELEASE, 8'd200, 16'd0);
        send_item(ffpa_pkg::ACT_RELEASE, 8'd5, 16'd0);
        send_item(ffpa_pkg::ACT_ALLOC, 8'd7, 16'd50);
        send_item(ffpa_pkg::ACT_RELEASE, 8'd0, 16'd0);
        send_item(ffpa_pkg::ACT_ALLOC, 8'd3, 16'd2500);
        send_item(ffpa_pkg::ACT_RELEASE, 8'd3, 16'd0);

        write_length(16'd1);
        send_item(ffpa_pkg::ACT_ALLOC, 8'd9, 16'd1);
        send_item(ffpa_pkg::ACT_ALLOC, 8'd10, 16'd1);
        write_length(16'd0);
        send_item(ffpa_pkg::ACT_ALLOC, 8'd11, 16'd0);
        send_item(ffpa_pkg::ACT_ALLOC, 8'd12, 16'd5);
        write_length(16'hFFFF);
        send_item(ffpa_pkg::ACT_ALLOC, 8'd13, 16'hFFFF);
        send_item(ffpa_pkg::ACT_RELEASE, 8'd13, 16'd0);

        // random phases, tight lengths push compaction
        write_length(16'd300);
        gap_pct = 20;
        repeat (340) random_item();
        write_length(16'd1200);
        gap_pct = 52;
        repeat (340) random_item();
        write_length(16'd65535);
        gap_pct = 0;
        repeat (340) random_item();

        drain();
        if (fail_count == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
